// ===== design/ffpa_pkg.sv =====
package ffpa_pkg;

  // field widths of the note and part words
  localparam int TIME_FIELD_W  = 32;
  localparam int INDEX_FIELD_W = 4;
  localparam int COUNT_FIELD_W = 5;

  // defaults for the top level parameters
  localparam int DEF_MAX_PARTS  = 16;
  localparam int DEF_TIME_WIDTH = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ffpa_state_t;

endpackage

// ===== design/ffpa_ifs.sv =====
interface ffpa_note_if import ffpa_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic [TIME_FIELD_W-1:0] start_ms;
  logic [TIME_FIELD_W-1:0] end_ms;
  logic                    last_of_track;

  modport source (output valid, start_ms, end_ms, last_of_track, input ready);
  modport sink   (input valid, start_ms, end_ms, last_of_track, output ready);
endinterface

interface ffpa_part_if import ffpa_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [INDEX_FIELD_W-1:0] part_index;
  logic                     opened_part;
  logic                     dropped;
  logic [COUNT_FIELD_W-1:0] parts_used;
  logic [TIME_FIELD_W-1:0]  part_latest_end;

  modport source (output valid, part_index, opened_part, dropped, parts_used,
                  part_latest_end, input ready);
  modport sink   (input valid, part_index, opened_part, dropped, parts_used,
                  part_latest_end, output ready);
endinterface

// ===== design/first_fit_note_part_allocator_unit.sv =====
// first-fit note part allocator
//
// note channel (sink): one word per note with start_ms, end_ms and
// last_of_track. part channel (source): one word per note with the part it
// went to, whether a part was opened, whether it was dropped, the number of
// open parts and that part's latest end time.
//
// a note is taken only while the sequencer is idle. it then walks the part
// end store one entry per cycle through a single registered memory read
// port and one shared less-than compare, stopping at the first part that
// does not clash.
//
// the result waits in an output register while the next note is taken. a
// stalled receiver holds a finished note and its store update in the final step
//
// reset (synchronous, rst high) closes all parts and empties the output
// register. the store itself is not cleared: only entries below the open
// part count are read, and each is written when its part opens. the note
// flagged last_of_track closes all parts after it is placed.
module first_fit_note_part_allocator_unit import ffpa_pkg::*; #(
  parameter int MAX_PARTS  = DEF_MAX_PARTS,
  parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  ffpa_note_if.sink   note,
  ffpa_part_if.source part
);

  localparam int IDX_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int CNT_W = $clog2(MAX_PARTS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PARTS);

  ffpa_state_t state, state_next;

  // latched note
  logic [TIME_WIDTH-1:0] s_reg;
  logic [TIME_WIDTH-1:0] e_reg;
  logic                  s_lt_e;
  logic                  last_reg;

  // scan pointer and the entry now sitting in the read register
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] chk_idx;
  logic             chk_vld;

  // first fit found during the scan
  logic                  found;
  logic [CNT_W-1:0]      hit_idx;
  logic [TIME_WIDTH-1:0] hit_end;

  logic [CNT_W-1:0] open_count;

  // part end store
  logic [TIME_WIDTH-1:0] mem [MAX_PARTS];
  logic [TIME_WIDTH-1:0] rd_data;

  // output register
  logic                     out_vld;
  logic [INDEX_FIELD_W-1:0] out_index;
  logic                     out_opened;
  logic                     out_dropped;
  logic [COUNT_FIELD_W-1:0] out_used;
  logic [TIME_FIELD_W-1:0]  out_latest;

  // sequencer controls
  logic                  accept;
  logic                  clash;
  logic                  hit_set;
  logic                  out_free;
  logic                  finish_go;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [TIME_WIDTH-1:0] wr_data;
  logic [CNT_W-1:0]      res_idx;
  logic                  res_opened;
  logic                  res_dropped;
  logic [CNT_W-1:0]      count_after;
  logic [TIME_WIDTH-1:0] res_latest;
  logic                  e_gt_old;

  assign accept   = note.valid && note.ready;
  assign out_free = !out_vld || part.ready;
  // the shared compare: start against the stored latest end
  assign clash    = s_lt_e && (s_reg < rd_data);
  assign e_gt_old = e_reg > hit_end;

  always_comb begin
    state_next  = state;
    note.ready  = 1'b0;
    hit_set     = 1'b0;
    finish_go   = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = open_count[IDX_W-1:0];
    wr_data     = e_reg;
    res_idx     = '0;
    res_opened  = 1'b0;
    res_dropped = 1'b0;
    count_after = open_count;
    res_latest  = '0;
    case (state)
      ST_IDLE: begin
        note.ready = 1'b1;
        if (note.valid) begin
          state_next = (open_count == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chk_vld && !clash) begin
          hit_set    = 1'b1;
          state_next = ST_FINISH;
        end else if (chk_vld && (CNT_W'(chk_idx + 1'b1) == open_count)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (found) begin
          // keep the larger of the old latest end and this end
          res_idx    = hit_idx;
          wr_addr    = hit_idx[IDX_W-1:0];
          res_latest = e_gt_old ? e_reg : hit_end;
          wr_en      = out_free && e_gt_old;
        end else if (open_count < MAX_CNT) begin
          // no part fits: open the next one
          res_idx     = open_count;
          res_opened  = 1'b1;
          res_latest  = e_reg;
          count_after = CNT_W'(open_count + 1'b1);
          wr_en       = out_free;
        end else begin
          res_dropped = 1'b1;
        end
        if (out_free) begin
          finish_go  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // store: one write port, one registered read port addressed by the scan
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[ptr[IDX_W-1:0]];
  end

  // note latch and scan datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      s_reg    <= TIME_WIDTH'(note.start_ms);
      e_reg    <= TIME_WIDTH'(note.end_ms);
      s_lt_e   <= TIME_WIDTH'(note.start_ms) < TIME_WIDTH'(note.end_ms);
      last_reg <= note.last_of_track;
      ptr      <= '0;
    end else if (state == ST_SCAN && ptr < open_count) begin
      ptr <= CNT_W'(ptr + 1'b1);
    end
    chk_idx <= ptr;
    if (hit_set) begin
      hit_idx <= chk_idx;
      hit_end <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld    <= 1'b0;
      found      <= 1'b0;
      open_count <= '0;
    end else begin
      if (accept) begin
        chk_vld <= 1'b0;
        found   <= 1'b0;
      end else begin
        chk_vld <= (state == ST_SCAN) && (ptr < open_count);
        if (hit_set) begin
          found <= 1'b1;
        end
      end
      if (finish_go) begin
        // parts_used reports the count before a track-end clear
        open_count <= last_reg ? '0 : count_after;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (finish_go) begin
      out_vld <= 1'b1;
    end else if (part.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      out_index   <= INDEX_FIELD_W'(res_idx);
      out_opened  <= res_opened;
      out_dropped <= res_dropped;
      out_used    <= COUNT_FIELD_W'(count_after);
      out_latest  <= TIME_FIELD_W'(res_latest);
    end
  end

  assign part.valid           = out_vld;
  assign part.part_index      = out_index;
  assign part.opened_part     = out_opened;
  assign part.dropped         = out_dropped;
  assign part.parts_used      = out_used;
  assign part.part_latest_end = out_latest;

endmodule
